// ===== rtl/frc_pkg.sv =====
package frc_pkg;

  localparam int unsigned HeaderBytes = 32;
  localparam int unsigned PosW        = $clog2(HeaderBytes);

  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;
  localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;

  localparam logic [31:0] LenCapReset = 32'h4000_0000;

  // Register map, word index
  localparam int unsigned RegW    = 3;
  localparam int unsigned AddrW   = RegW + 2;
  localparam logic [RegW-1:0] RegMagic   = 3'd0;
  localparam logic [RegW-1:0] RegVersion = 3'd1;
  localparam logic [RegW-1:0] RegAbi     = 3'd2;
  localparam logic [RegW-1:0] RegId      = 3'd3;
  localparam logic [RegW-1:0] RegOpcode  = 3'd4;
  localparam logic [RegW-1:0] RegLenCap  = 3'd5;

  // Header byte positions that complete a field
  localparam logic [PosW-1:0] PosMagic    = 5'd3;
  localparam logic [PosW-1:0] PosVersion  = 5'd5;
  localparam logic [PosW-1:0] PosKind     = 5'd7;
  localparam logic [PosW-1:0] PosAbi      = 5'd11;
  localparam logic [PosW-1:0] PosId       = 5'd15;
  localparam logic [PosW-1:0] PosOpcode   = 5'd17;
  localparam logic [PosW-1:0] PosStatus   = 5'd19;
  localparam logic [PosW-1:0] PosLength   = 5'd23;
  localparam logic [PosW-1:0] PosCrcFirst = 5'd24;
  localparam logic [PosW-1:0] PosCrcLast  = 5'd27;
  localparam logic [PosW-1:0] PosLast     = PosW'(HeaderBytes - 1);

  typedef enum logic [2:0] {
    VerdictOk       = 3'd0,
    VerdictMagic    = 3'd1,
    VerdictVersion  = 3'd2,
    VerdictReserved = 3'd3,
    VerdictAbi      = 3'd4,
    VerdictLength   = 3'd5,
    VerdictIdOp     = 3'd6,
    VerdictCrc      = 3'd7
  } verdict_e;

  typedef struct packed {
    logic [31:0] magic;
    logic [15:0] version;
    logic [31:0] abi;
    logic [31:0] id;
    logic [15:0] opcode;
    logic [31:0] len_cap;
  } cfg_t;

  // Reflected CRC-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'h0, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CrcPoly ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/frc_regs.sv =====
module frc_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [frc_pkg::AddrW-1:0]   paddr_i,
  input  logic [31:0]                 pwdata_i,
  output logic [31:0]                 prdata_o,
  output logic                        pready_o,
  output frc_pkg::cfg_t               cfg_o
);

  frc_pkg::cfg_t              cfg_q, cfg_d;
  logic [frc_pkg::RegW-1:0]   reg_idx;
  logic                       wr_en;

  assign reg_idx  = paddr_i[frc_pkg::AddrW-1:2];
  assign pready_o = 1'b1;
  assign wr_en    = psel_i && penable_i && pwrite_i;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        frc_pkg::RegMagic:   cfg_d.magic   = pwdata_i;
        frc_pkg::RegVersion: cfg_d.version = pwdata_i[15:0];
        frc_pkg::RegAbi:     cfg_d.abi     = pwdata_i;
        frc_pkg::RegId:      cfg_d.id      = pwdata_i;
        frc_pkg::RegOpcode:  cfg_d.opcode  = pwdata_i[15:0];
        frc_pkg::RegLenCap:  cfg_d.len_cap = pwdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      frc_pkg::RegMagic:   prdata_o = cfg_q.magic;
      frc_pkg::RegVersion: prdata_o = {16'h0, cfg_q.version};
      frc_pkg::RegAbi:     prdata_o = cfg_q.abi;
      frc_pkg::RegId:      prdata_o = cfg_q.id;
      frc_pkg::RegOpcode:  prdata_o = {16'h0, cfg_q.opcode};
      frc_pkg::RegLenCap:  prdata_o = cfg_q.len_cap;
      default:             prdata_o = 32'h0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{magic:   32'h0,
                 version: 16'h0,
                 abi:     32'h0,
                 id:      32'h0,
                 opcode:  16'h0,
                 len_cap: frc_pkg::LenCapReset};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/frame_response_checker_crc32.sv =====
// Response frame checker: takes one received byte per cycle on the rx channel and
// emits at most one result per byte on the res channel, in the cycle after acceptance.
// Each frame is a 32-byte little-endian header then a payload. Header checks (magic,
// version, reserved, peer ABI, length cap, id/opcode) are evaluated as each field
// completes; the last header byte closes the frame when a check fails or the payload
// length is zero. Payload bytes pass through, the last one carries the verdict. Any
// failure (including CRC mismatch) halts the block until reset: later bytes are
// accepted and dropped. Throughput is one byte per cycle; the byte-wide CRC update and
// the field compare sit between the rx input and the result register, and rx_ready_o
// falls only while a result waits unaccepted. Program registers over APB while idle.
module frame_response_checker_crc32 (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // APB configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [frc_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  // byte input
  input  logic                       rx_valid_i,
  output logic                       rx_ready_o,
  input  logic [7:0]                 rx_byte_i,
  // results
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output logic                       has_data_o,
  output logic [7:0]                 payload_byte_o,
  output logic                       frame_end_o,
  output logic [2:0]                 verdict_o,
  output logic [15:0]                frame_kind_o,
  output logic [15:0]                server_status_o,
  output logic [31:0]                peer_abi_o
);

  frc_pkg::cfg_t cfg;

  frc_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  logic [frc_pkg::PosW-1:0] pos_q, pos_d;
  logic                     in_payload_q, in_payload_d;
  logic                     halted_q, halted_d;
  logic [31:0]              shift_q, shift_d;
  logic [31:0]              crc_q, crc_d;
  logic [31:0]              carried_q, carried_d;
  logic [31:0]              left_q, left_d;
  frc_pkg::verdict_e        fail_q, fail_d;
  logic [15:0]              kind_q, kind_d;
  logic [15:0]              status_q, status_d;
  logic [31:0]              abi_q, abi_d;

  logic                     rx_acc;
  logic [31:0]              crc_base;
  frc_pkg::verdict_e        fail_base;
  frc_pkg::verdict_e        code;
  logic [7:0]               crc_in;

  logic                     res_load;
  logic                     res_data;
  logic [7:0]               res_byte;
  logic                     res_end;
  frc_pkg::verdict_e        res_verdict;

  logic                     res_valid_q;
  logic                     res_data_q;
  logic [7:0]               res_byte_q;
  logic                     res_end_q;
  frc_pkg::verdict_e        res_verdict_q;
  logic [15:0]              res_kind_q;
  logic [15:0]              res_status_q;
  logic [31:0]              res_abi_q;

  assign rx_ready_o = !res_valid_q || res_ready_i;
  assign rx_acc     = rx_valid_i && rx_ready_o;

  assign crc_base  = (pos_q == '0) ? frc_pkg::CrcInit : crc_q;
  assign fail_base = (pos_q == '0) ? frc_pkg::VerdictOk : fail_q;
  assign crc_in    = (pos_q >= frc_pkg::PosCrcFirst && pos_q <= frc_pkg::PosCrcLast) ?
                     8'h00 : rx_byte_i;

  always_comb begin
    pos_d        = pos_q;
    in_payload_d = in_payload_q;
    halted_d     = halted_q;
    shift_d      = shift_q;
    crc_d        = crc_q;
    carried_d    = carried_q;
    left_d       = left_q;
    fail_d       = fail_q;
    kind_d       = kind_q;
    status_d     = status_q;
    abi_d        = abi_q;
    code         = frc_pkg::VerdictOk;
    res_load     = 1'b0;
    res_data     = 1'b0;
    res_byte     = 8'h00;
    res_end      = 1'b0;
    res_verdict  = frc_pkg::VerdictOk;

    if (rx_acc && !halted_q) begin
      if (in_payload_q) begin
        crc_d    = frc_pkg::crc_byte(crc_q, rx_byte_i);
        left_d   = left_q - 32'd1;
        res_load = 1'b1;
        res_data = 1'b1;
        res_byte = rx_byte_i;
        if (left_d == 32'd0) begin
          in_payload_d = 1'b0;
          res_end      = 1'b1;
          if (~crc_d != carried_q) begin
            res_verdict = frc_pkg::VerdictCrc;
            halted_d    = 1'b1;
          end
        end
      end else begin
        shift_d = {rx_byte_i, shift_q[31:8]};
        crc_d   = frc_pkg::crc_byte(crc_base, crc_in);
        case (pos_q)
          frc_pkg::PosMagic:
            if (shift_d != cfg.magic) code = frc_pkg::VerdictMagic;
          frc_pkg::PosVersion:
            if (shift_d[31:16] != cfg.version) code = frc_pkg::VerdictVersion;
          frc_pkg::PosKind:
            kind_d = shift_d[31:16];
          frc_pkg::PosAbi: begin
            abi_d = shift_d;
            if (shift_d != cfg.abi) code = frc_pkg::VerdictAbi;
          end
          frc_pkg::PosId:
            if (shift_d != cfg.id) code = frc_pkg::VerdictIdOp;
          frc_pkg::PosOpcode:
            if (shift_d[31:16] != cfg.opcode) code = frc_pkg::VerdictIdOp;
          frc_pkg::PosStatus:
            status_d = shift_d[31:16];
          frc_pkg::PosLength: begin
            left_d = shift_d;
            if (shift_d > cfg.len_cap) code = frc_pkg::VerdictLength;
          end
          frc_pkg::PosCrcLast:
            carried_d = shift_d;
          frc_pkg::PosLast:
            if (shift_d != 32'd0) code = frc_pkg::VerdictReserved;
          default: ;
        endcase

        // keep the highest-priority (lowest nonzero) failure code
        if (code != frc_pkg::VerdictOk &&
            (fail_base == frc_pkg::VerdictOk || code < fail_base)) begin
          fail_d = code;
        end else begin
          fail_d = fail_base;
        end

        if (pos_q != frc_pkg::PosLast) begin
          pos_d = pos_q + 1'b1;
        end else begin
          pos_d = '0;
          if (fail_d != frc_pkg::VerdictOk) begin
            halted_d    = 1'b1;
            res_load    = 1'b1;
            res_end     = 1'b1;
            res_verdict = fail_d;
          end else if (left_d == 32'd0) begin
            res_load = 1'b1;
            res_end  = 1'b1;
            if (~crc_d != carried_d) begin
              res_verdict = frc_pkg::VerdictCrc;
              halted_d    = 1'b1;
            end
          end else begin
            in_payload_d = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      in_payload_q <= 1'b0;
      halted_q     <= 1'b0;
      shift_q      <= '0;
      crc_q        <= frc_pkg::CrcInit;
      carried_q    <= '0;
      left_q       <= '0;
      fail_q       <= frc_pkg::VerdictOk;
      kind_q       <= '0;
      status_q     <= '0;
      abi_q        <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      pos_q        <= pos_d;
      in_payload_q <= in_payload_d;
      halted_q     <= halted_d;
      shift_q      <= shift_d;
      crc_q        <= crc_d;
      carried_q    <= carried_d;
      left_q       <= left_d;
      fail_q       <= fail_d;
      kind_q       <= kind_d;
      status_q     <= status_d;
      abi_q        <= abi_d;
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // result payload, load only on a new transaction
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_data_q    <= res_data;
      res_byte_q    <= res_byte;
      res_end_q     <= res_end;
      res_verdict_q <= res_verdict;
      res_kind_q    <= kind_d;
      res_status_q  <= status_d;
      res_abi_q     <= abi_d;
    end
  end

  assign res_valid_o     = res_valid_q;
  assign has_data_o      = res_data_q;
  assign payload_byte_o  = res_byte_q;
  assign frame_end_o     = res_end_q;
  assign verdict_o       = res_verdict_q;
  assign frame_kind_o    = res_kind_q;
  assign server_status_o = res_status_q;
  assign peer_abi_o      = res_abi_q;

  a_halt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q && !res_valid_q |=> !res_valid_q)
    else $error("result produced while halted");

  a_verdict_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_verdict_q != frc_pkg::VerdictOk |-> res_end_q)
    else $error("nonzero verdict on a result that does not close a frame");

  a_fail_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_verdict_q != frc_pkg::VerdictOk |-> halted_q)
    else $error("failure reported without halting");

  a_payload_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_payload_q |-> pos_q == '0 && left_q != 32'd0)
    else $error("payload phase with header position or empty length");

endmodule
